// File: hw/rtl/datetime_string_parser_top_macros.svh
// Assertion macros for the date-time parser
`ifndef DATETIME_STRING_PARSER_TOP_MACROS_SVH
`define DATETIME_STRING_PARSER_TOP_MACROS_SVH

// same-cycle implication
`define DTSP_ASSERT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);

// next-cycle implication
`define DTSP_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);

`endif

// File: hw/rtl/dtsp_pkg.sv
package dtsp_pkg;

  localparam int DIG_NUM = 20;

  localparam logic [4:0] CNT_YEAR  = 5'd4;
  localparam logic [4:0] CNT_MONTH = 5'd6;
  localparam logic [4:0] CNT_DATE  = 5'd8;
  localparam logic [4:0] CNT_HOUR  = 5'd10;
  localparam logic [4:0] CNT_MIN   = 5'd12;
  localparam logic [4:0] CNT_SEC   = 5'd14;
  localparam logic [4:0] CNT_MS    = 5'd17;
  localparam logic [4:0] CNT_US    = 5'd20;
  localparam logic [4:0] CNT_SAT   = 5'd21;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DASH  = 8'h2d;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_COMMA = 8'h2c;

  localparam logic [1:0] SUB_DATE = 2'd0;
  localparam logic [1:0] SUB_SEC  = 2'd1;
  localparam logic [1:0] SUB_MS   = 2'd2;
  localparam logic [1:0] SUB_US   = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_CHAR  = 2'd1;
  localparam logic [1:0] ST_COUNT = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  localparam logic [13:0] YEAR_MIN  = 14'd1000;
  localparam logic [13:0] YEAR_MAX  = 14'd2400;
  localparam logic [6:0]  MONTH_MAX = 7'd12;
  localparam logic [6:0]  DAY_MAX   = 7'd31;
  localparam logic [6:0]  HOUR_MAX  = 7'd23;
  localparam logic [6:0]  MIN_MAX   = 7'd59;
  localparam logic [6:0]  SEC_MAX   = 7'd63;
  localparam logic [9:0]  FRAC_MAX  = 10'd999;

  typedef struct packed {
    logic       vld;
    logic [7:0] ch;
    logic       last;
  } chr_t;

  typedef struct packed {
    logic                          vld;
    logic [DIG_NUM-1:0][3:0]       dig;
    logic [4:0]                    cnt;
    logic                          ferr;
  } snap_t;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [9:0]  millisecond;
    logic [9:0]  microsecond;
    logic [1:0]  subtype;
    logic [1:0]  status;
  } res_t;

  function automatic logic [6:0] dec2(logic [3:0] a, logic [3:0] b);
    return 7'(a) * 7'd10 + 7'(b);
  endfunction

  function automatic logic [9:0] dec3(logic [3:0] a, logic [3:0] b, logic [3:0] c);
    return 10'(a) * 10'd100 + 10'(b) * 10'd10 + 10'(c);
  endfunction

  function automatic logic [13:0] dec4(logic [3:0] a, logic [3:0] b,
                                       logic [3:0] c, logic [3:0] d);
    return 14'(a) * 14'd1000 + 14'(b) * 14'd100 + 14'(c) * 14'd10 + 14'(d);
  endfunction

endpackage

// File: hw/rtl/dtsp_in_if.sv
interface dtsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       last;

  modport source (output valid, output ch, output last, input ready);
  modport sink   (input valid, input ch, input last, output ready);
endinterface

// File: hw/rtl/dtsp_out_if.sv
interface dtsp_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] year;
  logic [3:0]  month;
  logic [4:0]  day;
  logic [4:0]  hour;
  logic [5:0]  minute;
  logic [5:0]  second;
  logic [9:0]  millisecond;
  logic [9:0]  microsecond;
  logic [1:0]  subtype;
  logic [1:0]  status;

  modport source (output valid, output year, output month, output day, output hour,
                  output minute, output second, output millisecond,
                  output microsecond, output subtype, output status, input ready);
  modport sink   (input valid, input year, input month, input day, input hour,
                  input minute, input second, input millisecond,
                  input microsecond, input subtype, input status, output ready);
endinterface

// File: hw/rtl/dtsp_scan.sv
module dtsp_scan (
  input  logic            clk,
  input  logic            rst_n,
  input  dtsp_pkg::chr_t  chr,
  input  logic            snap_rdy,
  output logic            take,
  output dtsp_pkg::snap_t snap
);

  logic [4:0]                       cnt_r, cnt_nxt;
  logic                             ferr_r, ferr_nxt;
  logic [dtsp_pkg::DIG_NUM-1:0][3:0] dig_r, dig_nxt;
  logic                             is_dig;
  logic                             sep_ok;
  dtsp_pkg::snap_t                  snap_r;

  assign take = chr.vld && (!chr.last || snap_rdy);
  assign snap = snap_r;

  assign is_dig = (chr.ch >= dtsp_pkg::CH_ZERO) && (chr.ch <= dtsp_pkg::CH_NINE);

  assign sep_ok =
    ((cnt_r == dtsp_pkg::CNT_DATE) &&
     ((chr.ch == dtsp_pkg::CH_T) || (chr.ch == dtsp_pkg::CH_SPACE))) ||
    (((cnt_r == dtsp_pkg::CNT_YEAR) || (cnt_r == dtsp_pkg::CNT_MONTH)) &&
     (chr.ch == dtsp_pkg::CH_DASH)) ||
    (((cnt_r == dtsp_pkg::CNT_HOUR) || (cnt_r == dtsp_pkg::CNT_MIN)) &&
     (chr.ch == dtsp_pkg::CH_COLON)) ||
    ((cnt_r == dtsp_pkg::CNT_SEC) && (chr.ch == dtsp_pkg::CH_COMMA));

  always_comb begin
    dig_nxt  = dig_r;
    cnt_nxt  = cnt_r;
    ferr_nxt = ferr_r;
    if (take && !ferr_r) begin
      if (is_dig) begin
        for (int i = 0; i < dtsp_pkg::DIG_NUM; i++) begin
          if (cnt_r == 5'(i)) begin
            dig_nxt[i] = chr.ch[3:0];
          end
        end
        if (cnt_r < dtsp_pkg::CNT_SAT) begin
          cnt_nxt = cnt_r + 5'd1;
        end
      end else if (!sep_ok) begin
        ferr_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    dig_r <= dig_nxt;
    if (!rst_n) begin
      cnt_r  <= '0;
      ferr_r <= 1'b0;
    end else if (take && chr.last) begin
      cnt_r  <= '0;
      ferr_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      ferr_r <= ferr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      snap_r.vld <= 1'b0;
    end else if (snap_rdy) begin
      snap_r.vld <= take && chr.last;
    end
    if (take && chr.last) begin
      snap_r.dig  <= dig_nxt;
      snap_r.cnt  <= cnt_nxt;
      snap_r.ferr <= ferr_nxt;
    end
  end

endmodule

// File: hw/rtl/dtsp_decode.sv
module dtsp_decode (
  input  logic            clk,
  input  logic            rst_n,
  input  dtsp_pkg::snap_t snap,
  output logic            snap_rdy,
  dtsp_out_if.source      out_if
);

  logic            vld_r;
  dtsp_pkg::res_t  res_r;
  dtsp_pkg::res_t  res_nxt;
  logic [13:0]     yr;
  logic [6:0]      mo, dy, hr, mi, se;
  logic [9:0]      ms, us;
  logic [1:0]      sub;
  logic            cnt_ok;
  logic            has_time, has_ms, has_us;
  logic            rng_bad;

  assign snap_rdy = !vld_r || out_if.ready;

  assign yr = dtsp_pkg::dec4(snap.dig[0], snap.dig[1], snap.dig[2], snap.dig[3]);
  assign mo = dtsp_pkg::dec2(snap.dig[4], snap.dig[5]);
  assign dy = dtsp_pkg::dec2(snap.dig[6], snap.dig[7]);
  assign hr = dtsp_pkg::dec2(snap.dig[8], snap.dig[9]);
  assign mi = dtsp_pkg::dec2(snap.dig[10], snap.dig[11]);
  assign se = dtsp_pkg::dec2(snap.dig[12], snap.dig[13]);
  assign ms = dtsp_pkg::dec3(snap.dig[14], snap.dig[15], snap.dig[16]);
  assign us = dtsp_pkg::dec3(snap.dig[17], snap.dig[18], snap.dig[19]);

  always_comb begin
    cnt_ok = 1'b1;
    sub    = dtsp_pkg::SUB_DATE;
    case (snap.cnt)
      dtsp_pkg::CNT_DATE: sub = dtsp_pkg::SUB_DATE;
      dtsp_pkg::CNT_SEC:  sub = dtsp_pkg::SUB_SEC;
      dtsp_pkg::CNT_MS:   sub = dtsp_pkg::SUB_MS;
      dtsp_pkg::CNT_US:   sub = dtsp_pkg::SUB_US;
      default:            cnt_ok = 1'b0;
    endcase
  end

  assign has_time = (sub != dtsp_pkg::SUB_DATE);
  assign has_ms   = (sub == dtsp_pkg::SUB_MS) || (sub == dtsp_pkg::SUB_US);
  assign has_us   = (sub == dtsp_pkg::SUB_US);

  assign rng_bad =
    (yr < dtsp_pkg::YEAR_MIN) || (yr > dtsp_pkg::YEAR_MAX) ||
    (mo == 7'd0) || (mo > dtsp_pkg::MONTH_MAX) ||
    (dy == 7'd0) || (dy > dtsp_pkg::DAY_MAX) ||
    (has_time && ((hr > dtsp_pkg::HOUR_MAX) || (mi > dtsp_pkg::MIN_MAX) ||
                  (se > dtsp_pkg::SEC_MAX))) ||
    (has_ms && (ms > dtsp_pkg::FRAC_MAX)) ||
    (has_us && (us > dtsp_pkg::FRAC_MAX));

  always_comb begin
    res_nxt = '0;
    if (snap.ferr) begin
      res_nxt.status = dtsp_pkg::ST_CHAR;
    end else if (!cnt_ok) begin
      res_nxt.status = dtsp_pkg::ST_COUNT;
    end else if (rng_bad) begin
      res_nxt.status = dtsp_pkg::ST_RANGE;
    end else begin
      res_nxt.status = dtsp_pkg::ST_OK;
      res_nxt.year   = yr[11:0];
      res_nxt.month  = mo[3:0];
      res_nxt.day    = dy[4:0];
      res_nxt.subtype = sub;
      if (has_time) begin
        res_nxt.hour   = hr[4:0];
        res_nxt.minute = mi[5:0];
        res_nxt.second = se[5:0];
      end
      if (has_ms) begin
        res_nxt.millisecond = ms;
      end
      if (has_us) begin
        res_nxt.microsecond = us;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (snap_rdy) begin
      vld_r <= snap.vld;
    end
    if (snap_rdy && snap.vld) begin
      res_r <= res_nxt;
    end
  end

  assign out_if.valid       = vld_r;
  assign out_if.year        = res_r.year;
  assign out_if.month       = res_r.month;
  assign out_if.day         = res_r.day;
  assign out_if.hour        = res_r.hour;
  assign out_if.minute      = res_r.minute;
  assign out_if.second      = res_r.second;
  assign out_if.millisecond = res_r.millisecond;
  assign out_if.microsecond = res_r.microsecond;
  assign out_if.subtype     = res_r.subtype;
  assign out_if.status      = res_r.status;

endmodule

// File: hw/rtl/datetime_string_parser_top.sv
// Date-time string parser.
// in_if carries one ASCII character per transaction in ch, with last set on
// the final character of a string. out_if carries one result per string:
// year, month, day, hour, minute, second, millisecond, microsecond, subtype
// and status (0 ok, 1 illegal character, 2 bad digit count, 3 out of range).
// Fields not covered by the subtype, and all fields on error, read zero.
// Throughput: one character per cycle while in_if.ready is high, set by the
// single character scan stage; every stage takes a new transaction each
// cycle when downstream moves. A final character's result reaches out_if via the
// input register, scan and snapshot, and decode and result register stages.
// Reset (rst_n low, synchronous) empties all stages and clears the digit
// count and the illegal character flag.
// When the receiver stalls, the result register holds and the snapshot stage
// holds behind it; non-final characters are still scanned, and in_if.ready
// drops only while a final character waits in the input register for the
// result register to free.
`include "datetime_string_parser_top_macros.svh"

module datetime_string_parser_top (
  input logic       clk,
  input logic       rst_n,
  dtsp_in_if.sink   in_if,
  dtsp_out_if.source out_if
);

  logic            s1_v_r;
  logic [7:0]      s1_ch_r;
  logic            s1_last_r;
  dtsp_pkg::chr_t  chr;
  dtsp_pkg::snap_t snap;
  logic            take;
  logic            snap_rdy;

  assign in_if.ready = !s1_v_r || take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_if.ready) begin
      s1_v_r <= in_if.valid;
    end
    if (in_if.ready && in_if.valid) begin
      s1_ch_r   <= in_if.ch;
      s1_last_r <= in_if.last;
    end
  end

  assign chr.vld  = s1_v_r;
  assign chr.ch   = s1_ch_r;
  assign chr.last = s1_last_r;

  dtsp_scan u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .chr      (chr),
    .snap_rdy (snap_rdy),
    .take     (take),
    .snap     (snap)
  );

  dtsp_decode u_decode (
    .clk      (clk),
    .rst_n    (rst_n),
    .snap     (snap),
    .snap_rdy (snap_rdy),
    .out_if   (out_if)
  );

  `DTSP_ASSERT(a_err_zero,
    out_if.valid && (out_if.status != dtsp_pkg::ST_OK),
    (out_if.year == 12'd0) && (out_if.month == 4'd0) && (out_if.day == 5'd0) &&
    (out_if.subtype == dtsp_pkg::SUB_DATE),
    "error result carries non-zero fields")

  `DTSP_ASSERT(a_ok_range,
    out_if.valid && (out_if.status == dtsp_pkg::ST_OK),
    (out_if.year >= 12'd1000) && (out_if.year <= 12'd2400) && (out_if.month != 4'd0) &&
    (out_if.month <= 4'd12) && (out_if.day != 5'd0),
    "ok result with date out of range")

  `DTSP_ASSERT(a_date_only,
    out_if.valid && (out_if.status == dtsp_pkg::ST_OK) &&
    (out_if.subtype == dtsp_pkg::SUB_DATE),
    (out_if.hour == 5'd0) && (out_if.minute == 6'd0) && (out_if.second == 6'd0) &&
    (out_if.millisecond == 10'd0) && (out_if.microsecond == 10'd0),
    "date-only result carries time fields")

  `DTSP_ASSERT_NEXT(a_last_snap,
    s1_v_r && s1_last_r && snap_rdy,
    snap.vld,
    "final character did not reach the snapshot stage")

endmodule
